/* rtl/b2a_pkg.sv */
// Package for the binary to ASCII decimal converter.
// Holds widths, the place weights, the digit threshold rows and the stage type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b2a_pkg;

  localparam int unsigned NUM_DIGITS = 5;
  localparam int unsigned NUM_VALUES = 10;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CNT_W      = 3;
  // Nine times ten thousand does not fit in 16 bits.
  localparam int unsigned THR_W      = 17;

  // Upper two bits of a 6-bit ASCII digit, which is the digit ORed with 0x30.
  localparam logic [1:0] ASCII_ZONE = 2'b11;

  typedef logic [CHAR_W-1:0] char_t;
  typedef char_t [NUM_DIGITS-1:0] char_vec_t;
  typedef logic [NUM_VALUES-1:0][THR_W-1:0] thr_row_t;

  typedef struct packed {
    logic [VALUE_W-1:0] rest;
    char_vec_t          chars;
  } stage_t;

  localparam int unsigned PLACE_WEIGHT [NUM_DIGITS] = '{10000, 1000, 100, 10, 1};

  // Multiples 0..9 of one place weight.
  function automatic thr_row_t thr_row_f(input int unsigned weight);
    thr_row_t row;
    for (int d = 0; d < NUM_VALUES; d++) begin
      row[d] = THR_W'(d * weight);
    end
    return row;
  endfunction

endpackage

`default_nettype wire

/* rtl/b2a_intf.sv */
// Valid/ready channel interfaces for the binary to ASCII decimal converter.
// Depends on b2a_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface b2a_in_if import b2a_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2a_out_if import b2a_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_digit;
  logic              last_digit;

  modport source (output valid, output ascii_digit, output last_digit, input ready);
  modport sink   (input valid, input ascii_digit, input last_digit, output ready);
endinterface

`default_nettype wire

/* rtl/b2a_cell.sv */
// One digit cell: extracts the digit of one decimal place and passes the remainder on.
// Depends on b2a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b2a_cell import b2a_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire thr_row_t thr_i,
  input  wire logic     valid_i,
  input  wire stage_t   data_i,
  output logic          ready_o,
  output logic          valid_o,
  output stage_t        data_o,
  input  wire logic     ready_i
);

  logic               valid_q;
  stage_t             data_q, data_d;
  logic [DIGIT_W-1:0] digit;
  logic [THR_W-1:0]   rem;

  // The thresholds rise with the digit, so the highest one passed is the digit.
  always_comb begin
    digit = '0;
    for (int d = 1; d < NUM_VALUES; d++) begin
      if ({1'b0, data_i.rest} >= thr_i[d]) begin
        digit = DIGIT_W'(d);
      end
    end
    rem          = {1'b0, data_i.rest} - thr_i[digit];
    data_d.rest  = rem[VALUE_W-1:0];
    data_d.chars = {data_i.chars[NUM_DIGITS-2:0], ASCII_ZONE, digit};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/b2a_serializer.sv */
// Output stage: holds a request's five chars, sends one per cycle while ready_i is set.
// Depends on b2a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b2a_serializer import b2a_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  wire char_vec_t chars_i,
  output logic           ready_o,
  output logic           valid_o,
  output char_t          ascii_digit_o,
  output logic           last_digit_o,
  input  wire logic      ready_i
);

  char_vec_t          chars_q, chars_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               send;

  assign valid_o       = (cnt_q != '0);
  assign ascii_digit_o = chars_q[NUM_DIGITS-1];
  assign last_digit_o  = (cnt_q == CNT_W'(1));
  assign send          = valid_o && ready_i;
  // A new request loads while the final character is taken.
  assign ready_o       = (cnt_q == '0) || (last_digit_o && ready_i);

  always_comb begin
    chars_d = chars_q;
    cnt_d   = cnt_q;
    if (send) begin
      chars_d = {chars_q[NUM_DIGITS-2:0], char_t'(0)};
      cnt_d   = cnt_q - CNT_W'(1);
    end
    if (valid_i && ready_o) begin
      chars_d = chars_i;
      cnt_d   = CNT_W'(NUM_DIGITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NUM_DIGITS))
    else $error("character count out of range");

  a_load_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> cnt_q == CNT_W'(NUM_DIGITS))
    else $error("load did not set a full character count");

  a_keep_going: assert property (@(posedge clk_i) disable iff (!rst_ni)
    send && !last_digit_o |=> valid_o)
    else $error("request dropped before its last character");

  a_ascii_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ascii_digit_o[CHAR_W-1:CHAR_W-2] == ASCII_ZONE
             && ascii_digit_o[DIGIT_W-1:0] <= DIGIT_W'(9))
    else $error("character is not an ASCII decimal digit");

endmodule

`default_nettype wire

/* rtl/binary_to_ascii_decimal_core.sv */
// 16-bit unsigned value to five ASCII decimal characters, most significant first.
// Each request passes through the five digit cell registers and then into the output stage.
// The output stage sends one character per cycle while out_if.ready is high.
// Five digit cells run as a pipeline, so up to six requests are in flight at once.
// Reset clears all valid flags and the character count; data registers are not reset.
// Depends on b2a_pkg, b2a_intf, b2a_cell and b2a_serializer.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_ascii_decimal_core import b2a_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  b2a_in_if.sink     in_if,
  b2a_out_if.source  out_if
);

  logic   [NUM_DIGITS:0] valid_c;
  logic   [NUM_DIGITS:0] ready_c;
  stage_t [NUM_DIGITS:0] data_c;

  assign valid_c[0]         = in_if.valid;
  assign data_c[0].rest     = in_if.value;
  assign data_c[0].chars    = '0;
  assign in_if.ready        = ready_c[0];

  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
    b2a_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .thr_i   (thr_row_f(PLACE_WEIGHT[k])),
      .valid_i (valid_c[k]),
      .data_i  (data_c[k]),
      .ready_o (ready_c[k]),
      .valid_o (valid_c[k+1]),
      .data_o  (data_c[k+1]),
      .ready_i (ready_c[k+1])
    );
  end

  b2a_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_c[NUM_DIGITS]),
    .chars_i       (data_c[NUM_DIGITS].chars),
    .ready_o       (ready_c[NUM_DIGITS]),
    .valid_o       (out_if.valid),
    .ascii_digit_o (out_if.ascii_digit),
    .last_digit_o  (out_if.last_digit),
    .ready_i       (out_if.ready)
  );

endmodule

`default_nettype wire
